FILE: rtl/core/ierts_pkg.sv
// Package for the ICMP echo-reply round-trip-time statistics block.
// Item types, parser result type and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ierts_pkg;

  // Input item: one packet byte with its receive time
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        last_byte;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_item_t;

  // Result item: per-packet verdict and running statistics
  typedef struct packed {
    logic        accepted;
    logic [31:0] rtt_us;
    logic [31:0] max_rtt_us;
    logic [31:0] min_rtt_us;
    logic [47:0] rtt_sum;
    logic [63:0] rtt_square_sum;
    logic [31:0] reply_count;
  } out_item_t;

  // Parser view of the packet as it stands after the current byte
  typedef struct packed {
    logic        ok;
    logic [31:0] sent_sec;
    logic [31:0] sent_usec;
  } parse_res_t;

  localparam logic [31:0] USEC_PER_SEC  = 32'd1000000;
  localparam logic [31:0] MIN_RTT_RESET = 32'd999999000;
  localparam logic [47:0] SUM_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX       = 32'hFFFF_FFFF;
  // 2^32 seconds expressed in microseconds, removed when the seconds delta is negative
  localparam logic [63:0] WRAP_USEC     = {USEC_PER_SEC, 32'd0};

  localparam int unsigned ICMP_MIN_LEN  = 8;
  localparam int unsigned ID_LO_OFF     = 4;
  localparam int unsigned ID_HI_OFF     = 5;
  localparam int unsigned TIME_OFF      = 8;
  localparam logic [7:0]  ECHO_REPLY    = 8'd0;

endpackage

`default_nettype wire

FILE: rtl/core/ierts_stream_if.sv
// Valid/ready channel carrying one item of type T.
// Used for the byte input, the result output and the configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface ierts_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ierts_parse.sv
// Byte-wise IPv4/ICMP header parser: header length, type, identifier, send time.
// Depends on ierts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ierts_parse
  import ierts_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 4096,
  parameter int unsigned TIME_WORD_BYTES  = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire in_item_t   item,
  input  wire logic [15:0] echo_id,
  output parse_res_t      res
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CW = PW + 8;

  logic [PW-1:0] byte_position;
  logic [5:0]    header_length;
  logic [7:0]    reply_type_seen;
  logic [15:0]   ident_bytes;
  logic [31:0]   sent_seconds;
  logic [31:0]   sent_micros;

  logic [PW-1:0] len_next;
  logic [5:0]    hl_next;
  logic [7:0]    type_next;
  logic [15:0]   ident_next;
  logic [31:0]   sec_next;
  logic [31:0]   usec_next;
  logic          in_range;
  logic [CW-1:0] off;

  // next capture values for the byte on the input
  always_comb begin
    in_range   = byte_position < PW'(MAX_PACKET_BYTES);
    hl_next    = header_length;
    type_next  = reply_type_seen;
    ident_next = ident_bytes;
    sec_next   = sent_seconds;
    usec_next  = sent_micros;
    len_next   = byte_position;
    off        = '0;
    if (in_range) begin
      len_next = PW'(byte_position + 1'b1);
      // first byte: new header length, captures start from zero
      if (byte_position == '0) begin
        hl_next    = {item.rx_byte[3:0], 2'b00};
        type_next  = '0;
        ident_next = '0;
        sec_next   = '0;
        usec_next  = '0;
      end
      if (CW'(byte_position) >= CW'(hl_next)) begin
        off = CW'(byte_position) - CW'(hl_next);
        if (off == '0) type_next = item.rx_byte;
        if (off == CW'(ID_LO_OFF)) ident_next[7:0]  = item.rx_byte;
        if (off == CW'(ID_HI_OFF)) ident_next[15:8] = item.rx_byte;
        // only the low four bytes of each time word are kept
        for (int i = 0; i < 4; i++) begin
          if (off == CW'(TIME_OFF + i))
            sec_next[8*i +: 8] = item.rx_byte;
          if (off == CW'(TIME_OFF + TIME_WORD_BYTES + i))
            usec_next[8*i +: 8] = item.rx_byte;
        end
      end
    end
  end

  // verdict as it would stand if this byte closes the packet
  always_comb begin
    res.ok = (CW'(len_next) >= CW'(hl_next) + CW'(ICMP_MIN_LEN)) &&
             (type_next == ECHO_REPLY) && (ident_next == echo_id);
    res.sent_sec  = sec_next;
    res.sent_usec = usec_next;
  end

  // capture registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_length   <= '0;
      reply_type_seen <= '0;
      ident_bytes     <= '0;
      sent_seconds    <= '0;
      sent_micros     <= '0;
    end else if (take) begin
      header_length   <= hl_next;
      reply_type_seen <= type_next;
      ident_bytes     <= ident_next;
      sent_seconds    <= sec_next;
      sent_micros     <= usec_next;
      byte_position   <= item.last_byte ? '0 : len_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/icmp_echo_reply_rtt_stats.sv
// ICMP echo-reply round-trip-time statistics, top level.
// Depends on ierts_pkg, ierts_stream_if and ierts_parse.
//
// Packet bytes are taken one per cycle while rx.ready is high. On the byte
// marked last, a rejected packet goes straight to the result-loading step; an
// accepted reply runs through an 11-step sequence on one shared 64-bit
// adder/comparator and one 32x32 multiplier (seconds delta, scale to
// microseconds, wrap correction, microsecond add and subtract, clamp, square,
// sum, square sum, max, min), then loads the result register; only after that
// is the next byte taken. The result register holds the
// item until result.ready; the sequencer waits on it only at its final step.
// Configuration (echo_id) is written whenever cfg.valid is high.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_rtt_stats
  import ierts_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 4096,
  parameter int unsigned TIME_WORD_BYTES  = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ierts_stream_if.sink   rx,
  ierts_stream_if.source result,
  ierts_stream_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_BYTES, S_DIFF, S_MULS, S_CORR, S_ADDU, S_SUBM, S_CLAMP,
    S_SQ, S_SUM, S_SQS, S_MAX, S_MIN, S_DONE
  } state_t;

  state_t      state;
  logic [15:0] echo_id;
  parse_res_t  pres;
  logic        take;

  logic        pkt_ok;
  logic [31:0] now_s;
  logic [19:0] now_u;
  logic [31:0] sent_s;
  logic [31:0] sent_u;
  logic [63:0] acc;
  logic        d_neg;
  logic [31:0] rtt;
  logic [63:0] sq;

  logic [31:0] max_rtt;
  logic [31:0] min_rtt;
  logic [47:0] sum_rtt;
  logic [63:0] sum_sq;
  logic [31:0] count_replies;

  logic        res_valid;
  out_item_t   res_data;

  // shared unit operands and results
  logic [63:0] add_a, add_b;
  logic        add_sub;
  logic [64:0] add_res;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign take         = rx.valid && rx.ready;
  assign rx.ready     = (state == S_BYTES);
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  ierts_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .TIME_WORD_BYTES  (TIME_WORD_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (rx.data),
    .echo_id (echo_id),
    .res     (pres)
  );

  // operand selection for the shared adder and multiplier
  always_comb begin
    add_a   = acc;
    add_b   = '0;
    add_sub = 1'b0;
    mul_a   = rtt;
    mul_b   = rtt;
    unique case (state)
      S_DIFF: begin
        add_a   = {32'd0, now_s};
        add_b   = {32'd0, sent_s};
        add_sub = 1'b1;
      end
      S_MULS: begin
        mul_a = acc[31:0];
        mul_b = USEC_PER_SEC;
      end
      S_CORR: begin
        add_b   = d_neg ? WRAP_USEC : 64'd0;
        add_sub = 1'b1;
      end
      S_ADDU: add_b = {44'd0, now_u};
      S_SUBM: begin
        add_b   = {32'd0, sent_u};
        add_sub = 1'b1;
      end
      S_SUM: begin
        add_a = {16'd0, sum_rtt};
        add_b = {32'd0, rtt};
      end
      S_SQS: begin
        add_a = sum_sq;
        add_b = sq;
      end
      S_MAX: begin
        add_a   = {32'd0, max_rtt};
        add_b   = {32'd0, rtt};
        add_sub = 1'b1;
      end
      S_MIN: begin
        add_a   = {32'd0, rtt};
        add_b   = {32'd0, min_rtt};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 65'(add_sub);
    mul_p   = 64'(mul_a) * 64'(mul_b);
  end

  // sequencer, statistics and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_BYTES;
      echo_id       <= '0;
      pkt_ok        <= 1'b0;
      max_rtt       <= '0;
      min_rtt       <= MIN_RTT_RESET;
      sum_rtt       <= '0;
      sum_sq        <= '0;
      count_replies <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) echo_id <= cfg.data;
      // the final step reloads the register itself
      if (result.ready && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_BYTES: begin
          if (take && rx.data.last_byte) begin
            pkt_ok <= pres.ok;
            now_s  <= rx.data.now_sec;
            now_u  <= rx.data.now_usec;
            sent_s <= pres.sent_sec;
            sent_u <= pres.sent_usec;
            state  <= pres.ok ? S_DIFF : S_DONE;
          end
        end
        S_DIFF: begin
          acc   <= {32'd0, add_res[31:0]};
          state <= S_MULS;
        end
        S_MULS: begin
          acc   <= mul_p;
          d_neg <= acc[31];
          state <= S_CORR;
        end
        S_CORR: begin
          acc   <= add_res[63:0];
          state <= S_ADDU;
        end
        S_ADDU: begin
          acc   <= add_res[63:0];
          state <= S_SUBM;
        end
        S_SUBM: begin
          acc   <= add_res[63:0];
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          // negative total to zero, above 32 bits to all ones
          if (acc[63])                rtt <= '0;
          else if (acc[63:32] != '0)  rtt <= U32_MAX;
          else                        rtt <= acc[31:0];
          state <= S_SQ;
        end
        S_SQ: begin
          sq    <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          sum_rtt <= (add_res[48] ? SUM_MAX : add_res[47:0]);
          state   <= S_SQS;
        end
        S_SQS: begin
          sum_sq <= add_res[64] ? '1 : add_res[63:0];
          state  <= S_MAX;
        end
        S_MAX: begin
          // borrow: max below rtt
          if (!add_res[64]) max_rtt <= rtt;
          state <= S_MIN;
        end
        S_MIN: begin
          if (!add_res[64]) min_rtt <= rtt;
          if (count_replies != U32_MAX) count_replies <= count_replies + 32'd1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid               <= 1'b1;
            res_data.accepted       <= pkt_ok;
            res_data.rtt_us         <= pkt_ok ? rtt : 32'd0;
            res_data.max_rtt_us     <= max_rtt;
            res_data.min_rtt_us     <= min_rtt;
            res_data.rtt_sum        <= sum_rtt;
            res_data.rtt_square_sum <= sum_sq;
            res_data.reply_count    <= count_replies;
            state                   <= S_BYTES;
          end
        end
        default: state <= S_BYTES;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ierts_check.sv
// Port-level checks for icmp_echo_reply_rtt_stats, with the bind that attaches them.
// Depends on ierts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ierts_check
  import ierts_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      rx_valid,
  input wire logic      rx_ready,
  input wire in_item_t  rx_data,
  input wire logic      res_valid,
  input wire logic      res_ready,
  input wire out_item_t res_data
);

  // a stalled result item holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result item changed while stalled");

  // byte intake is stopped in the cycle after the closing byte of a packet
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready && rx_data.last_byte |=> !rx_ready)
    else $error("byte taken right after a closing byte");

  // a rejected packet reports zero round-trip time
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.accepted |-> res_data.rtt_us == 32'd0)
    else $error("rejected packet with non-zero rtt");

  // an accepted reply lies inside the running extremes and is counted
  a_accept_bounds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.accepted |->
      res_data.min_rtt_us <= res_data.rtt_us && res_data.rtt_us <= res_data.max_rtt_us &&
      res_data.reply_count != 32'd0)
    else $error("accepted rtt outside min/max or count zero");

endmodule

bind icmp_echo_reply_rtt_stats ierts_check u_ierts_check (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx.valid),
  .rx_ready  (rx.ready),
  .rx_data   (rx.data),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

`default_nettype wire

FILE: bench/icmp_echo_reply_rtt_stats_test.sv
// Testbench for icmp_echo_reply_rtt_stats: sends IPv4 packets byte by byte,
// predicts the per-packet verdict and running RTT statistics, checks each result.
// Depends on ierts_pkg, ierts_stream_if and the block under test.
`timescale 1ns / 1ps

import ierts_pkg::*;

// Packet parser and statistics predictor, plus the queue of due results
class rtt_stats_scoreboard;
  localparam int unsigned MAX_BYTES = 4096;
  localparam int unsigned TIME_WORD = 8;

  logic [15:0] echo_id;
  int unsigned byte_pos;
  int unsigned hdr_len;
  logic [7:0]  msg_type;
  logic [15:0] ident;
  logic [31:0] sent_sec;
  logic [31:0] sent_usec;
  logic [31:0] max_rtt;
  logic [31:0] min_rtt;
  logic [47:0] sum_rtt;
  logic [63:0] sum_sq;
  logic [31:0] replies;
  out_item_t   stats_due[$];
  int          failures;

  function new();
    echo_id   = '0;
    byte_pos  = 0;
    hdr_len   = 0;
    msg_type  = '0;
    ident     = '0;
    sent_sec  = '0;
    sent_usec = '0;
    max_rtt   = '0;
    min_rtt   = MIN_RTT_RESET;
    sum_rtt   = '0;
    sum_sq    = '0;
    replies   = '0;
    failures  = 0;
  endfunction

  function void write_echo_id(logic [15:0] id);
    echo_id = id;
  endfunction

  // One accepted byte; the byte marked last closes the packet and queues a result
  function void note_byte(in_item_t it);
    out_item_t   want;
    int unsigned off;
    int unsigned k;
    logic [31:0] dsec;
    longint      signed_sec;
    longint      total;
    logic [31:0] rtt;
    logic [48:0] wide_sum;
    logic [63:0] sq;
    bit          ok;
    if (byte_pos < MAX_BYTES) begin
      // first byte sets the header length and clears the capture fields
      if (byte_pos == 0) begin
        hdr_len   = 32'({it.rx_byte[3:0], 2'b00});
        msg_type  = '0;
        ident     = '0;
        sent_sec  = '0;
        sent_usec = '0;
      end
      if (byte_pos >= hdr_len) begin
        off = byte_pos - hdr_len;
        if (off == 0) begin
          msg_type = it.rx_byte;
        end else if (off == ID_LO_OFF) begin
          ident[7:0] = it.rx_byte;
        end else if (off == ID_HI_OFF) begin
          ident[15:8] = it.rx_byte;
        end else if (off >= TIME_OFF && off < TIME_OFF + TIME_WORD) begin
          k = off - TIME_OFF;
          if (k < 4) sent_sec[8*k +: 8] = it.rx_byte;
        end else if (off >= TIME_OFF + TIME_WORD && off < TIME_OFF + 2 * TIME_WORD) begin
          k = off - TIME_OFF - TIME_WORD;
          if (k < 4) sent_usec[8*k +: 8] = it.rx_byte;
        end
      end
      byte_pos++;
    end
    if (!it.last_byte) return;

    ok = byte_pos >= hdr_len + ICMP_MIN_LEN && msg_type == ECHO_REPLY && ident == echo_id;
    byte_pos = 0;
    rtt = '0;
    if (ok) begin
      // seconds delta read as signed, then total microseconds with clamp at both ends
      dsec = it.now_sec - sent_sec;
      signed_sec = $signed(dsec);
      total = signed_sec * 1000000 + longint'(it.now_usec) - longint'(sent_usec);
      if (total < 0) rtt = '0;
      else if (total > 64'sd4294967295) rtt = '1;
      else rtt = total[31:0];

      if (rtt > max_rtt) max_rtt = rtt;
      if (rtt < min_rtt) min_rtt = rtt;
      wide_sum = {1'b0, sum_rtt} + {17'd0, rtt};
      sum_rtt = (wide_sum > {1'b0, SUM_MAX}) ? SUM_MAX : wide_sum[47:0];
      sq = {32'd0, rtt} * {32'd0, rtt};
      sum_sq = (sq > ~sum_sq) ? '1 : sum_sq + sq;
      if (replies != U32_MAX) replies++;
    end

    want.accepted       = ok;
    want.rtt_us         = rtt;
    want.max_rtt_us     = max_rtt;
    want.min_rtt_us     = min_rtt;
    want.rtt_sum        = sum_rtt;
    want.rtt_square_sum = sum_sq;
    want.reply_count    = replies;
    stats_due.push_back(want);
  endfunction

  task report_mismatch(string what);
    failures++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Compare one result item against the oldest due result
  task check_result(out_item_t got);
    out_item_t want;
    if (stats_due.size() == 0) begin
      report_mismatch("result item with no packet pending");
      return;
    end
    want = stats_due.pop_front();
    compare_field("accepted", 64'(got.accepted), 64'(want.accepted));
    compare_field("rtt_us", 64'(got.rtt_us), 64'(want.rtt_us));
    compare_field("max_rtt_us", 64'(got.max_rtt_us), 64'(want.max_rtt_us));
    compare_field("min_rtt_us", 64'(got.min_rtt_us), 64'(want.min_rtt_us));
    compare_field("rtt_sum", 64'(got.rtt_sum), 64'(want.rtt_sum));
    compare_field("rtt_square_sum", got.rtt_square_sum, want.rtt_square_sum);
    compare_field("reply_count", 64'(got.reply_count), 64'(want.reply_count));
  endtask
endclass

module icmp_echo_reply_rtt_stats_test;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned SENT_WORD       = 8;

  logic clk;
  logic rst;

  ierts_stream_if #(.T(in_item_t))    rx_ch ();
  ierts_stream_if #(.T(out_item_t))   result_ch ();
  ierts_stream_if #(.T(logic [15:0])) cfg_ch ();

  icmp_echo_reply_rtt_stats dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rtt_stats_scoreboard stats = new();

  logic [7:0]  frame[$];
  logic [15:0] cur_id;
  bit          steady;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run time limit
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check at the rising edge, choose ready at the falling edge
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) stats.check_result(result_ch.data);
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else begin
        result_ch.ready = steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // Offer one byte, with an occasional one-cycle gap before it; returns at the next falling edge
  task automatic push_byte(input in_item_t it);
    if (!steady && $urandom_range(99) < 15) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.data  = it;
    rx_ch.valid = 1'b1;
    do @(posedge clk); while (!rx_ch.ready);
    stats.note_byte(it);
    @(negedge clk);
  endtask

  // Time fields only matter on the last byte; elsewhere they are noise
  task automatic send_frame(input logic [31:0] now_s, input logic [19:0] now_u);
    in_item_t it;
    foreach (frame[i]) begin
      it.rx_byte   = frame[i];
      it.last_byte = (i == frame.size() - 1);
      it.now_sec   = it.last_byte ? now_s : $urandom;
      it.now_usec  = it.last_byte ? now_u : 20'($urandom);
      push_byte(it);
    end
  endtask

  // Build an IPv4 packet carrying an ICMP message of icmp_len bytes.
  // With ihl 0 the ICMP type byte is also byte 0, so its low nibble must be 0.
  function automatic void make_reply(input logic [3:0] ihl, input logic [7:0] msg_type,
                                     input logic [15:0] id, input logic [31:0] sent_s,
                                     input logic [31:0] sent_u, input int unsigned icmp_len);
    logic [7:0]  b;
    int unsigned off;
    frame.delete();
    if (ihl != 0) begin
      frame.push_back({4'($urandom), ihl});
      repeat (4 * ihl - 1) frame.push_back(8'($urandom));
    end
    for (off = 0; off < icmp_len; off++) begin
      b = 8'($urandom);
      if (off == 0) b = (ihl == 0) ? {msg_type[7:4], 4'h0} : msg_type;
      else if (off == ID_LO_OFF) b = id[7:0];
      else if (off == ID_HI_OFF) b = id[15:8];
      else if (off >= TIME_OFF && off < TIME_OFF + 4)
        b = sent_s[8*(off - TIME_OFF) +: 8];
      else if (off >= TIME_OFF + SENT_WORD && off < TIME_OFF + SENT_WORD + 4)
        b = sent_u[8*(off - TIME_OFF - SENT_WORD) +: 8];
      frame.push_back(b);
    end
  endfunction

  function automatic void make_noise(input int unsigned len);
    frame.delete();
    repeat (len) frame.push_back(8'($urandom));
  endfunction

  // Realistic send/receive times: mostly a few seconds apart, never negative
  function automatic void pick_times(output logic [31:0] sent_s, output logic [31:0] sent_u,
                                     output logic [31:0] now_s, output logic [19:0] now_u);
    int unsigned dsec;
    logic [19:0] swap;
    dsec   = ($urandom_range(9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 60);
    sent_s = $urandom;
    sent_u = $urandom_range(0, 999999);
    now_s  = sent_s + dsec;
    now_u  = 20'($urandom_range(0, 999999));
    if (dsec == 0 && now_u < sent_u) begin
      swap   = now_u;
      now_u  = sent_u[19:0];
      sent_u = {12'd0, swap};
    end
  endfunction

  // Mostly matching replies, some wrong type, wrong id, short or plain noise
  task automatic random_packet();
    logic [31:0] ss, su, ns;
    logic [19:0] nu;
    logic [3:0]  ihl;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(99);
    ihl  = ($urandom_range(9) != 0) ? 4'($urandom_range(0, 2)) : 4'($urandom);
    len  = ($urandom_range(4) != 0) ? $urandom_range(20, 26) : $urandom_range(8, 19);
    pick_times(ss, su, ns, nu);
    if (pick < 72)
      make_reply(ihl, ECHO_REPLY, cur_id, ss, su, len);
    else if (pick < 80)
      make_reply(4'($urandom_range(1, 3)), 8'($urandom_range(1, 255)), cur_id, ss, su, len);
    else if (pick < 86)
      make_reply(ihl, ECHO_REPLY, cur_id ^ (16'd1 << $urandom_range(15)), ss, su, len);
    else if (pick < 92)
      make_reply(4'($urandom_range(1, 3)), ECHO_REPLY, cur_id, ss, su, $urandom_range(1, 7));
    else
      make_noise($urandom_range(1, 24));
    send_frame(ns, nu);
  endtask

  task automatic random_phase(input int unsigned packets, input bit with_hold_off);
    for (int unsigned n = 0; n < packets; n++) begin
      if (with_hold_off && n == 1) hold_request = HOLD_OFF_CYCLES;
      random_packet();
    end
  endtask

  task automatic write_echo_id(input logic [15:0] id);
    cfg_ch.data  = id;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    stats.write_echo_id(id);
    cur_id = id;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait for every due result, then let the sequencer settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    rx_ch.valid = 1'b0;
    while (stats.stats_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    rx_ch.valid  = 1'b0;
    rx_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    steady       = 1'b0;
    hold_request = 0;
    cur_id       = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: ordinary reply, boundary lengths and rejects
    write_echo_id(16'h0000);
    make_reply(4'd5, ECHO_REPLY, 16'h0000, 32'd100, 32'd250000, 20);
    send_frame(32'd101, 20'd500000);
    // ICMP part one byte short of the minimum
    make_reply(4'd1, ECHO_REPLY, 16'h0000, 32'd0, 32'd0, 7);
    send_frame(32'd1, 20'd0);
    // exactly the minimum: send time never arrives and reads as zero
    make_reply(4'd1, ECHO_REPLY, 16'h0000, 32'd0, 32'd0, 8);
    send_frame(32'd0, 20'd123);
    // seconds word only, microseconds word missing
    make_reply(4'd2, ECHO_REPLY, 16'h0000, 32'd40, 32'd0, 12);
    send_frame(32'd42, 20'd17);
    // echo request instead of reply
    make_reply(4'd1, 8'd8, 16'h0000, 32'd0, 32'd0, 8);
    send_frame(32'd1, 20'd0);
    // identifier mismatch in the high byte
    make_reply(4'd1, ECHO_REPLY, 16'h0100, 32'd0, 32'd0, 8);
    send_frame(32'd1, 20'd0);
    // header length beyond the end of the packet
    make_noise(20);
    frame[0] = 8'h4F;
    send_frame(32'd1, 20'd0);
    // single-byte packet
    make_noise(1);
    send_frame(32'($urandom), 20'($urandom));
    // longest header with a full reply
    make_reply(4'd15, ECHO_REPLY, 16'h0000, 32'd9, 32'd999999, 20);
    send_frame(32'd10, 20'd1);
    drain();

    // Random phases: all-ones id with a long result hold-off, then a random id
    // with no idling at all, then another random id with idling
    write_echo_id(16'hFFFF);
    random_phase(4, 1'b1);
    drain();

    steady = 1'b1;
    write_echo_id(16'($urandom));
    random_phase(3, 1'b0);
    drain();
    steady = 1'b0;

    write_echo_id(16'($urandom));
    random_phase(2, 1'b0);
    drain();

    // Directed extremes last, since they pin max, min and the square sum
    // (no IPv4 header here: ICMP starts at byte 0)
    write_echo_id(16'h8001);
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'hFFFF_FFFE, 32'd999999, 20);
    send_frame(32'd1, 20'd0);
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'd3, 32'd0, 20);
    send_frame(32'd3, 20'hFFFFF);
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'd0, 32'hFFFF_FFFF, 20);
    send_frame(32'd5000, 20'd0);
    // huge round trip saturates; twice overflows the square sum
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'd0, 32'd0, 20);
    send_frame(32'h7FFF_FFFF, 20'd0);
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'd0, 32'd0, 20);
    send_frame(32'h7FFF_FFFF, 20'hFFFFF);
    // seconds delta at the sign boundary counts as negative and clamps to zero
    make_reply(4'd0, ECHO_REPLY, 16'h8001, 32'd0, 32'd0, 20);
    send_frame(32'h8000_0000, 20'd0);
    drain();

    if (stats.stats_due.size() != 0)
      stats.report_mismatch($sformatf("%0d packet results never arrived",
                                      stats.stats_due.size()));
    if (stats.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
